// File: hw/rtl/kpc_pkg.sv
// Shared types, codes and constants for the key press classifier.
// Used by kpc_key and key_press_classifier; depends on nothing else.
package kpc_pkg;

  localparam int NUM_KEYS   = 4;
  localparam int PIN_WIDTH  = 4;
  localparam int CODE_WIDTH = 4;
  localparam int HOLD_WIDTH = 8;
  localparam int GAP_WIDTH  = 6;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};
  localparam logic [HOLD_WIDTH-1:0] LONG_PRESS_RESET    = 8'd70;
  localparam logic [GAP_WIDTH-1:0]  DOUBLE_WINDOW_RESET = 6'd20;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_WINDOW = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_ENABLE = 2'd2;

  localparam logic [CODE_WIDTH-1:0] EV_NONE        = CODE_WIDTH'(0);
  localparam logic [CODE_WIDTH-1:0] EV_SINGLE_BASE = CODE_WIDTH'(1);
  localparam logic [CODE_WIDTH-1:0] EV_LONG_BASE   = CODE_WIDTH'(1 + NUM_KEYS);
  localparam logic [CODE_WIDTH-1:0] EV_DOUBLE_BASE = CODE_WIDTH'(1 + 2 * NUM_KEYS);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [HOLD_WIDTH-1:0] long_press_ticks;
    logic [GAP_WIDTH-1:0]  double_window_ticks;
    logic                  double_enable;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic released;
    logic clr_sgl;
    logic clr_lng;
    logic clr_dbl;
  } key_ctrl_t;

  typedef struct packed {
    logic sgl;
    logic lng;
    logic dbl;
  } key_flags_t;

endpackage

// File: hw/rtl/kpc_key.sv
// Per-key debounce, hold timing and press classification for one button.
// Depends on kpc_pkg for the phase type, config and control structs.
module kpc_key
  import kpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  key_ctrl_t  ctrl,
  output key_flags_t flags
);

  phase_t                phase, phase_next;
  logic [HOLD_WIDTH-1:0] hold_count, hold_count_next;
  logic [GAP_WIDTH-1:0]  gap_count, gap_count_next;
  logic                  awaiting, awaiting_next;
  key_flags_t            flags_next;
  logic                  release_held;
  logic                  short_press;

  assign release_held = (phase == PH_HELD) && ctrl.released;
  assign short_press  = release_held && (hold_count < cfg.long_press_ticks);

  always_comb begin
    phase_next = phase;
    if (ctrl.tick) begin
      unique case (phase)
        PH_DEBOUNCE: phase_next = ctrl.released ? PH_IDLE : PH_HELD;
        PH_HELD:     phase_next = ctrl.released ? PH_IDLE : PH_HELD;
        default:     phase_next = ctrl.released ? PH_IDLE : PH_DEBOUNCE;
      endcase
    end
  end

  always_comb begin
    hold_count_next = hold_count;
    gap_count_next  = gap_count;
    awaiting_next   = awaiting;
    flags_next      = flags;
    if (ctrl.tick) begin
      if (phase != PH_DEBOUNCE && phase != PH_HELD && !ctrl.released) begin
        hold_count_next = '0;
      end
      if (phase == PH_HELD && !ctrl.released && hold_count != HOLD_MAX) begin
        hold_count_next = hold_count + HOLD_WIDTH'(1);
      end
      if (release_held && !short_press) begin
        flags_next.lng = 1'b1;
      end
      if (short_press) begin
        if (!cfg.double_enable) begin
          flags_next.sgl = 1'b1;
        end else if (!awaiting) begin
          awaiting_next  = 1'b1;
          gap_count_next = '0;
        end else begin
          flags_next.dbl = 1'b1;
          awaiting_next  = 1'b0;
        end
      end
      if (awaiting_next) begin
        gap_count_next = gap_count_next + GAP_WIDTH'(1);
        if (gap_count_next >= cfg.double_window_ticks) begin
          awaiting_next  = 1'b0;
          flags_next.sgl = 1'b1;
        end
      end
    end else begin
      if (ctrl.clr_sgl) flags_next.sgl = 1'b0;
      if (ctrl.clr_lng) flags_next.lng = 1'b0;
      if (ctrl.clr_dbl) flags_next.dbl = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
      gap_count  <= '0;
      awaiting   <= 1'b0;
      flags      <= '0;
    end else begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
      gap_count  <= gap_count_next;
      awaiting   <= awaiting_next;
      flags      <= flags_next;
    end
  end

endmodule

// File: hw/rtl/key_press_classifier.sv
// Top level of the key press classifier: configuration registers, scan
// priority and the result register. Depends on kpc_pkg and kpc_key.
//
// Each input transaction is either a tick, which samples the four active-low
// pins and advances every key's debounce and hold timing, or a scan, which
// reports and clears the lowest-numbered key's pending event (single, then
// long, then double). Every transaction produces exactly one result, held in
// a result register and shown in the cycle after acceptance together with the
// pending flags as they stand after that transaction. One transaction is
// accepted per cycle while the input is ready: the per-key state update is
// registered on acceptance, and the input is ready whenever the result
// register is empty or being taken in the same cycle. Configuration writes are
// always ready and take effect on the next transaction.
module key_press_classifier
  import kpc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [PIN_WIDTH-1:0]       pin_levels,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CODE_WIDTH-1:0]      event_code,
  output logic [NUM_KEYS-1:0]        single_pending,
  output logic [NUM_KEYS-1:0]        long_pending,
  output logic [NUM_KEYS-1:0]        double_pending,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t                  cfg;
  logic                  accept;
  logic                  is_tick;
  key_ctrl_t             ctrl [NUM_KEYS];
  key_flags_t            flags [NUM_KEYS];
  logic [NUM_KEYS-1:0]   released;
  logic [NUM_KEYS-1:0]   sgl_now, lng_now, dbl_now;
  logic [NUM_KEYS-1:0]   clr_sgl, clr_lng, clr_dbl;
  logic [CODE_WIDTH-1:0] code_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_tick   = (command == CMD_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks    <= LONG_PRESS_RESET;
      cfg.double_window_ticks <= DOUBLE_WINDOW_RESET;
      cfg.double_enable       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS:    cfg.long_press_ticks    <= cfg_data[HOLD_WIDTH-1:0];
        REG_DOUBLE_WINDOW: cfg.double_window_ticks <= cfg_data[GAP_WIDTH-1:0];
        REG_DOUBLE_ENABLE: cfg.double_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    code_next = EV_NONE;
    clr_sgl   = '0;
    clr_lng   = '0;
    clr_dbl   = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (sgl_now[k]) begin
        code_next = EV_SINGLE_BASE + CODE_WIDTH'(k);
        clr_sgl   = '0;
        clr_lng   = '0;
        clr_dbl   = '0;
        clr_sgl[k] = 1'b1;
      end else if (lng_now[k]) begin
        code_next = EV_LONG_BASE + CODE_WIDTH'(k);
        clr_sgl   = '0;
        clr_lng   = '0;
        clr_dbl   = '0;
        clr_lng[k] = 1'b1;
      end else if (dbl_now[k]) begin
        code_next = EV_DOUBLE_BASE + CODE_WIDTH'(k);
        clr_sgl   = '0;
        clr_lng   = '0;
        clr_dbl   = '0;
        clr_dbl[k] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    if (k < PIN_WIDTH) begin : g_pin
      assign released[k] = pin_levels[k];
    end else begin : g_nopin
      assign released[k] = 1'b0;
    end

    assign sgl_now[k] = flags[k].sgl;
    assign lng_now[k] = flags[k].lng;
    assign dbl_now[k] = flags[k].dbl;

    always_comb begin
      ctrl[k].tick     = accept && is_tick;
      ctrl[k].released = released[k];
      ctrl[k].clr_sgl  = accept && !is_tick && clr_sgl[k];
      ctrl[k].clr_lng  = accept && !is_tick && clr_lng[k];
      ctrl[k].clr_dbl  = accept && !is_tick && clr_dbl[k];
    end

    kpc_key u_key (
      .clk   (clk),
      .rst   (rst),
      .cfg   (cfg),
      .ctrl  (ctrl[k]),
      .flags (flags[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= is_tick ? EV_NONE : code_next;
    end
  end

  assign single_pending = sgl_now;
  assign long_pending   = lng_now;
  assign double_pending = dbl_now;

`ifndef SYNTHESIS
  a_tick_no_event: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick |=> event_code == EV_NONE)
    else $error("tick transaction reported an event");

  a_scan_empty: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick && ({sgl_now, lng_now, dbl_now} == '0) |=> event_code == EV_NONE)
    else $error("scan reported an event with nothing pending");

  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick && ({sgl_now, lng_now, dbl_now} != '0) |=> event_code != EV_NONE)
    else $error("scan missed a pending event");

  a_scan_clears_one: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick && ({sgl_now, lng_now, dbl_now} != '0) |=>
      $countones({sgl_now, lng_now, dbl_now}) ==
      $past($countones({sgl_now, lng_now, dbl_now})) - 1)
    else $error("scan did not clear exactly one pending event");

  a_idle_holds_flags: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable({sgl_now, lng_now, dbl_now}))
    else $error("pending flags changed without a transaction");
`endif

endmodule
